// File: src/sensor_triggered_ramp_envelope_macros.svh
// ---------------------------------------------------------------------------
// sensor triggered ramp envelope assertion macros
// shared assertion wrappers for the envelope block
// ---------------------------------------------------------------------------
`ifndef SENSOR_TRIGGERED_RAMP_ENVELOPE_MACROS_SVH
`define SENSOR_TRIGGERED_RAMP_ENVELOPE_MACROS_SVH

// checked only outside reset
`define SRE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define SRE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/sre_pkg.sv
// ---------------------------------------------------------------------------
// sre_pkg
// types and constants of the sensor triggered ramp envelope
// ---------------------------------------------------------------------------
package sre_pkg;

  localparam int NUM_CHANNELS = 4;

  typedef enum logic [2:0] {
    REG_TRIGGER_THRESHOLD   = 3'd0,
    REG_MAX_LEVEL           = 3'd1,
    REG_HOLD_START_MS       = 3'd2,
    REG_RAMP_DOWN_START_MS  = 3'd3,
    REG_STAGGER_MS          = 3'd4,
    REG_FIRST_STEP_INTERVAL = 3'd5
  } sre_reg_t;

  localparam logic [15:0] RST_TRIGGER_THRESHOLD   = 16'd1200;
  localparam logic [7:0]  RST_MAX_LEVEL           = 8'd150;
  localparam logic [15:0] RST_HOLD_START_MS       = 16'd3000;
  localparam logic [15:0] RST_RAMP_DOWN_START_MS  = 16'd4000;
  localparam logic [15:0] RST_STAGGER_MS          = 16'd500;
  localparam logic [15:0] RST_FIRST_STEP_INTERVAL = 16'd1;

  typedef struct packed {
    logic [1:0]  unit_index;
    logic [31:0] now_ms;
    logic [15:0] ir_level;
  } sre_in_t;

  typedef struct packed {
    logic [1:0] unit_out;
    logic [7:0] level_0;
    logic [7:0] level_1;
    logic [7:0] level_2;
    logic [7:0] level_3;
    logic       active;
  } sre_out_t;

  typedef struct packed {
    logic [15:0] trigger_threshold;
    logic [7:0]  max_level;
    logic [15:0] hold_start_ms;
    logic [15:0] ramp_down_start_ms;
    logic [15:0] stagger_ms;
    logic [15:0] first_step_interval;
  } sre_cfg_t;

  typedef struct packed {
    logic                               cycling;
    logic [31:0]                        phase_start;
    logic [31:0]                        last_step;
    logic [31:0]                        step_interval;
    logic [NUM_CHANNELS-1:0][7:0]       levels;
  } sre_entry_t;

endpackage

// File: src/sre_state_mem.sv
// ---------------------------------------------------------------------------
// sre_state_mem
// per-unit state memory, registered read, valid bit per entry
// ---------------------------------------------------------------------------
module sre_state_mem #(
  parameter int NUM_UNITS = 4,
  parameter int AW = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output sre_pkg::sre_entry_t rd_entry,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  sre_pkg::sre_entry_t wr_entry
);
  import sre_pkg::*;

  sre_entry_t            mem [NUM_UNITS];
  logic [NUM_UNITS-1:0]  vld;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= vld[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

// File: src/sre_update.sv
// ---------------------------------------------------------------------------
// sre_update
// one tick of the envelope for the unit read from memory
// ---------------------------------------------------------------------------
module sre_update (
  input  sre_pkg::sre_in_t    item,
  input  logic                in_range,
  input  sre_pkg::sre_cfg_t   cfg,
  input  sre_pkg::sre_entry_t cur,
  output sre_pkg::sre_entry_t nxt,
  output sre_pkg::sre_out_t   result
);
  import sre_pkg::*;

  logic [31:0] cyc;
  logic [31:0] since_step;
  logic        due;
  logic        start;
  logic [16:0] stag2;
  logic [17:0] stag3;
  logic [NUM_CHANNELS-1:0] extra;
  logic [NUM_CHANNELS-1:0][7:0] up_lv;
  logic [NUM_CHANNELS-1:0][7:0] dn_lv;
  logic [7:0]  first_inc;
  logic [31:0] interval_inc;

  assign cyc        = item.now_ms - cur.phase_start;
  assign since_step = item.now_ms - cur.last_step;
  assign due        = since_step > cur.step_interval;
  assign start      = (item.ir_level > cfg.trigger_threshold) && !cur.cycling;
  assign stag2      = {cfg.stagger_ms, 1'b0};
  assign stag3      = {2'b00, cfg.stagger_ms} + {1'b0, cfg.stagger_ms, 1'b0};

  assign extra[0] = 1'b1;
  assign extra[1] = cyc > {16'd0, cfg.stagger_ms};
  assign extra[2] = cyc > {15'd0, stag2};
  assign extra[3] = cyc > {14'd0, stag3};

  assign interval_inc = (cur.step_interval != '1) ? cur.step_interval + 32'd1
                                                  : cur.step_interval;

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      first_inc = (cur.levels[c] < cfg.max_level) ? cur.levels[c] + 8'd1 : cur.levels[c];
      up_lv[c]  = (extra[c] && (first_inc < cfg.max_level)) ? first_inc + 8'd1 : first_inc;
      dn_lv[c]  = (cur.levels[c] != 8'd0) ? cur.levels[c] - 8'd1 : cur.levels[c];
    end
  end

  always_comb begin
    nxt = cur;
    if (start) begin
      nxt.cycling       = 1'b1;
      nxt.phase_start   = item.now_ms;
      nxt.last_step     = item.now_ms;
      nxt.step_interval = {16'd0, cfg.first_step_interval};
    end else if (cur.cycling) begin
      if (cyc > {16'd0, cfg.ramp_down_start_ms}) begin
        if (due) begin
          nxt.levels        = dn_lv;
          nxt.last_step     = item.now_ms;
          nxt.step_interval = interval_inc;
        end
        // cycle ends once every channel is down to zero
        if (nxt.levels == '0) begin
          nxt.cycling = 1'b0;
        end
      end else if (cyc > {16'd0, cfg.hold_start_ms}) begin
        // hold phase
        nxt = cur;
      end else if (due) begin
        nxt.levels        = up_lv;
        nxt.last_step     = item.now_ms;
        nxt.step_interval = interval_inc;
      end
    end
  end

  always_comb begin
    result.unit_out = item.unit_index;
    if (in_range) begin
      result.level_0 = nxt.levels[0];
      result.level_1 = nxt.levels[1];
      result.level_2 = nxt.levels[2];
      result.level_3 = nxt.levels[3];
      result.active  = nxt.cycling;
    end else begin
      result.level_0 = '0;
      result.level_1 = '0;
      result.level_2 = '0;
      result.level_3 = '0;
      result.active  = 1'b0;
    end
  end

endmodule

// File: src/sensor_triggered_ramp_envelope.sv
// ---------------------------------------------------------------------------
// sensor_triggered_ramp_envelope
// per-unit ir triggered ramp up / hold / ramp down of four drive levels
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake               beat
//  -------  ---  ----------------------  ---------------------------------
//  in       in   in_valid / in_stall     unit_index, now_ms, ir_level
//  out      out  out_valid / out_stall   unit_out, level_0..3, active
//  cfg      in   cfg_we                  cfg_index, cfg_data
//
//  one beat per cycle sustained while out_stall is low; a result is formed from
//  its input beat by the registered memory read, then update and write back
//  the single state memory with its registered read sets the latency
//  reset is synchronous, clears the entry valid bits and config; no sweep
//  out_stall holds the result register, which stalls the update stage and
//  raises in_stall while that stage is full
//
`include "sensor_triggered_ramp_envelope_macros.svh"

module sensor_triggered_ramp_envelope #(
  parameter int NUM_UNITS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sre_pkg::sre_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sre_pkg::sre_out_t out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import sre_pkg::*;

  localparam int AW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

  // configuration registers
  sre_cfg_t cfg;

  // update stage: item whose state is coming out of memory
  logic       s1_valid;
  sre_in_t    s1_item;
  logic       s1_in_range;
  logic [AW-1:0] s1_addr;

  // last write back, forwarded to the following item of the same unit
  logic       wb_valid;
  logic [AW-1:0] wb_addr;
  sre_entry_t wb_entry;

  logic [7:0]    in_idx_ext;
  logic [AW-1:0] in_addr;
  logic          in_range;
  logic          accept;
  logic          s1_adv;
  logic          s1_fire;
  logic          wr_en;
  sre_entry_t    rd_entry;
  sre_entry_t    s1_entry;
  sre_entry_t    upd_entry;
  sre_out_t      upd_out;

  assign in_idx_ext = {6'd0, in_data.unit_index};
  assign in_addr    = in_idx_ext[AW-1:0];
  assign in_range   = int'(in_idx_ext) < NUM_UNITS;

  // handshake
  assign s1_adv   = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = s1_fire && s1_in_range;

  // memory was read at the same edge the previous item wrote back
  assign s1_entry = (wb_valid && (wb_addr == s1_addr)) ? wb_entry : rd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_threshold   <= RST_TRIGGER_THRESHOLD;
      cfg.max_level           <= RST_MAX_LEVEL;
      cfg.hold_start_ms       <= RST_HOLD_START_MS;
      cfg.ramp_down_start_ms  <= RST_RAMP_DOWN_START_MS;
      cfg.stagger_ms          <= RST_STAGGER_MS;
      cfg.first_step_interval <= RST_FIRST_STEP_INTERVAL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_THRESHOLD:   cfg.trigger_threshold   <= cfg_data;
        REG_MAX_LEVEL:           cfg.max_level           <= cfg_data[7:0];
        REG_HOLD_START_MS:       cfg.hold_start_ms       <= cfg_data;
        REG_RAMP_DOWN_START_MS:  cfg.ramp_down_start_ms  <= cfg_data;
        REG_STAGGER_MS:          cfg.stagger_ms          <= cfg_data;
        REG_FIRST_STEP_INTERVAL: cfg.first_step_interval <= cfg_data;
        default: ; // unused index, write dropped
      endcase
    end
  end

  // update stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item     <= in_data;
      s1_in_range <= in_range;
      s1_addr     <= in_addr;
    end
  end

  // forwarding register
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (s1_fire) begin
      wb_valid <= wr_en;
    end else if (accept) begin
      wb_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      wb_addr  <= s1_addr;
      wb_entry <= upd_entry;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= upd_out;
    end
  end

  sre_state_mem #(
    .NUM_UNITS (NUM_UNITS),
    .AW        (AW)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (in_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (s1_addr),
    .wr_entry (upd_entry)
  );

  sre_update u_update (
    .item     (s1_item),
    .in_range (s1_in_range),
    .cfg      (cfg),
    .cur      (s1_entry),
    .nxt      (upd_entry),
    .result   (upd_out)
  );

  // assertions
  `SRE_ASSERT(a_stall_only_when_full, in_stall |-> (s1_valid && out_valid && out_stall), "input stalled with a free update stage")
  `SRE_ASSERT(a_accept_fills_stage, (in_valid && !in_stall) |=> s1_valid, "accepted beat did not reach the update stage")
  `SRE_ASSERT(a_fire_gives_result, (s1_valid && !in_stall) |=> out_valid, "update stage fired without a result")
  `SRE_ASSERT_ALWAYS(a_reset_empties, rst |=> (!out_valid && !s1_valid && !wb_valid), "pipeline not empty after reset")

endmodule

// File: tb/sensor_triggered_ramp_envelope_tb.sv
// ---------------------------------------------------------------------------
// sensor_triggered_ramp_envelope_tb
// drives per-unit sensor ticks through several register settings, predicts
// every result beat with its own envelope model and checks them in order
// ---------------------------------------------------------------------------
module sensor_triggered_ramp_envelope_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sre_pkg::*;

  localparam int NUM_UNITS   = 4;
  localparam int IDLE_LIMIT  = 1000;  // cycles with no beat on either side
  localparam int PHASE_TICKS = 160;

  // cfg indexes past the last register, writes there must be ignored
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  sre_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  sre_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sensor_triggered_ramp_envelope #(
    .NUM_UNITS(NUM_UNITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // shadow registers, follow every cfg write
  logic [15:0] cfg_thr  = RST_TRIGGER_THRESHOLD;
  logic [7:0]  cfg_max  = RST_MAX_LEVEL;
  logic [15:0] cfg_hold = RST_HOLD_START_MS;
  logic [15:0] cfg_rd   = RST_RAMP_DOWN_START_MS;
  logic [15:0] cfg_stg  = RST_STAGGER_MS;
  logic [15:0] cfg_fsi  = RST_FIRST_STEP_INTERVAL;

  // predicted per-unit envelope state, all zero after reset
  logic        run_on   [NUM_UNITS];
  logic [31:0] t_start  [NUM_UNITS];
  logic [31:0] last_st  [NUM_UNITS];
  logic [31:0] st_int   [NUM_UNITS];
  logic [7:0]  lvl      [NUM_UNITS][NUM_CHANNELS];

  sre_in_t  tick_q[$];      // ticks waiting to be driven
  sre_out_t levels_due[$];  // predicted result beats, oldest first

  logic [31:0] unit_clock [NUM_UNITS];  // per-unit millisecond time of the stimulus

  int  ticks_sent = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  settings_done = 0;
  int  idle_cycles = 0;
  bit  in_taken = 1'b0;
  bit  in_quiet = 1'b0;
  bit  out_quiet = 1'b0;
  int  in_gap = 0;
  int  stall_left = 0;
  int  out_cycles = 0;

  initial begin
    for (int u = 0; u < NUM_UNITS; u++) begin
      run_on[u] = 1'b0;
      t_start[u] = '0;
      last_st[u] = '0;
      st_int[u] = '0;
      unit_clock[u] = $urandom;
      for (int c = 0; c < NUM_CHANNELS; c++) lvl[u][c] = '0;
    end
  end

  // one step up, never past the ceiling
  function automatic logic [7:0] bump(input logic [7:0] v);
    return (v < cfg_max) ? v + 8'd1 : v;
  endfunction

  // advance one unit by one tick, return the levels it reports
  function automatic sre_out_t envelope_tick(input sre_in_t t);
    sre_out_t    r;
    int          u;
    logic [31:0] cyc;
    logic [31:0] since;
    logic        due;
    logic        all_zero;
    r = '0;
    u = int'(t.unit_index);
    r.unit_out = t.unit_index;
    if (u >= NUM_UNITS) begin
      return r;
    end
    if (t.ir_level > cfg_thr && !run_on[u]) begin
      // start: levels stay as they are, no step on this tick
      run_on[u] = 1'b1;
      t_start[u] = t.now_ms;
      last_st[u] = t.now_ms;
      st_int[u] = {16'd0, cfg_fsi};
    end else if (run_on[u]) begin
      cyc = t.now_ms - t_start[u];
      since = t.now_ms - last_st[u];
      due = since > st_int[u];
      // ramp-down test comes before the hold test
      if (cyc > {16'd0, cfg_rd}) begin
        if (due) begin
          for (int c = 0; c < NUM_CHANNELS; c++)
            if (lvl[u][c] != 8'd0) lvl[u][c] = lvl[u][c] - 8'd1;
          if (st_int[u] != 32'hFFFF_FFFF) st_int[u] = st_int[u] + 32'd1;
          last_st[u] = t.now_ms;
        end
        all_zero = 1'b1;
        for (int c = 0; c < NUM_CHANNELS; c++)
          if (lvl[u][c] != 8'd0) all_zero = 1'b0;
        if (all_zero) run_on[u] = 1'b0;
      end else if (cyc > {16'd0, cfg_hold}) begin
        // hold
      end else if (due) begin
        for (int c = 0; c < NUM_CHANNELS; c++) lvl[u][c] = bump(lvl[u][c]);
        lvl[u][0] = bump(lvl[u][0]);
        if (cyc > {16'd0, cfg_stg}) lvl[u][1] = bump(lvl[u][1]);
        if (cyc > {16'd0, cfg_stg} * 32'd2) lvl[u][2] = bump(lvl[u][2]);
        if (cyc > {16'd0, cfg_stg} * 32'd3) lvl[u][3] = bump(lvl[u][3]);
        if (st_int[u] != 32'hFFFF_FFFF) st_int[u] = st_int[u] + 32'd1;
        last_st[u] = t.now_ms;
      end
    end
    r.level_0 = lvl[u][0];
    r.level_1 = lvl[u][1];
    r.level_2 = lvl[u][2];
    r.level_3 = lvl[u][3];
    r.active = run_on[u];
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int gap_len(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // accept side: predict input beats, check result beats, watch for a hang
  always @(posedge clk) begin
    bit beat;
    bit bad;
    sre_out_t want;
    beat = 1'b0;
    if (!rst && in_valid && !in_stall) begin
      levels_due.push_back(envelope_tick(in_data));
      ticks_sent++;
      in_taken = 1'b1;
      beat = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      beat = 1'b1;
      results_seen++;
      if (levels_due.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, got unit %0d levels %0d %0d %0d %0d",
                 $time, out_data.unit_out, out_data.level_0, out_data.level_1,
                 out_data.level_2, out_data.level_3);
        $display("%0t:   active %0b", $time, out_data.active);
      end else begin
        want = levels_due.pop_front();
        bad = (out_data.unit_out !== want.unit_out) || (out_data.level_0 !== want.level_0) ||
              (out_data.level_1 !== want.level_1) || (out_data.level_2 !== want.level_2) ||
              (out_data.level_3 !== want.level_3) || (out_data.active !== want.active);
        if (bad) begin
          mismatches++;
          $display("%0t: mismatch expected u%0d %0d %0d %0d %0d a%0b got u%0d %0d %0d %0d %0d a%0b",
                   $time, want.unit_out, want.level_0, want.level_1, want.level_2,
                   want.level_3, want.active, out_data.unit_out, out_data.level_0,
                   out_data.level_1, out_data.level_2, out_data.level_3, out_data.active);
        end
      end
    end
    if (rst || beat) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results still due", $time, idle_cycles,
               levels_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // tick driver, a stalled beat holds its payload
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (tick_q.size() > 0) begin
        in_data <= tick_q.pop_front();
        in_valid <= 1'b1;
        if (ticks_sent % 40 == 0) in_quiet = ($urandom_range(0, 3) == 0);
        in_gap = gap_len(in_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_cycles++;
      if (out_cycles % 50 == 0) out_quiet = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = gap_len(out_quiet);
      end
    end
  end

  task automatic add_tick(input int u, input logic [31:0] now, input logic [15:0] ir);
    sre_in_t t;
    t.unit_index = u[1:0];
    t.now_ms = now;
    t.ir_level = ir;
    tick_q.push_back(t);
  endtask

  // block is idle: every tick taken, every result back, pipe drained
  task automatic wait_idle();
    while (tick_q.size() != 0 || in_valid || levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_TRIGGER_THRESHOLD:   cfg_thr = val;
      REG_MAX_LEVEL:           cfg_max = val[7:0];
      REG_HOLD_START_MS:       cfg_hold = val;
      REG_RAMP_DOWN_START_MS:  cfg_rd = val;
      REG_STAGGER_MS:          cfg_stg = val;
      REG_FIRST_STEP_INTERVAL: cfg_fsi = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] thr, input logic [7:0] mx,
                               input logic [15:0] hold, input logic [15:0] rd,
                               input logic [15:0] stg, input logic [15:0] fsi);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    write_reg(REG_SPARE_LO, 16'($urandom_range(0, 65535)));
    write_reg(REG_TRIGGER_THRESHOLD, thr);
    write_reg(REG_MAX_LEVEL, {junk, mx});  // upper byte is not part of the register
    write_reg(REG_HOLD_START_MS, hold);
    write_reg(REG_RAMP_DOWN_START_MS, rd);
    write_reg(REG_STAGGER_MS, stg);
    write_reg(REG_FIRST_STEP_INTERVAL, fsi);
    write_reg(REG_SPARE_HI, 16'($urandom_range(0, 65535)));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  task automatic random_setting();
    logic [15:0] hold;
    logic [15:0] rd;
    hold = 16'($urandom_range(20, 400));
    rd = hold + 16'($urandom_range(0, 300));
    apply_setting(16'($urandom_range(0, 65535)), 8'($urandom_range(1, 40)), hold, rd,
                  16'($urandom_range(0, 80)), 16'($urandom_range(0, 6)));
  endtask

  // random ticks: mostly short time steps so cycles run their course,
  // some long jumps and a few arbitrary ones
  task automatic random_ticks(input int n);
    int          span;
    int          u;
    int          r;
    logic [31:0] d;
    logic [15:0] ir;
    span = cfg_rd / 16 + 8;
    if (span > 200) span = 200;
    for (int i = 0; i < n; i++) begin
      u = $urandom_range(0, NUM_UNITS - 1);
      r = $urandom_range(0, 99);
      if (r < 82) d = $urandom_range(0, span);
      else if (r < 97) d = $urandom_range(0, 2000);
      else d = $urandom;
      unit_clock[u] = unit_clock[u] + d;
      if ($urandom_range(0, 99) < 35 && cfg_thr != 16'hFFFF)
        ir = 16'($urandom_range(cfg_thr + 1, 65535));
      else
        ir = 16'($urandom_range(0, 65535));
      add_tick(u, unit_clock[u], ir);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed ticks under the reset settings
    add_tick(0, 32'hFFFF_FF00, 16'd1200);             // equal to threshold: stays idle
    add_tick(0, 32'hFFFF_FF00, 16'd1201);             // starts, levels kept
    add_tick(0, 32'hFFFF_FF01, 16'd0);                // one ms: step not yet due
    add_tick(0, 32'hFFFF_FF02, 16'd0);                // first step
    add_tick(0, 32'hFFFF_FF05, 16'hFFFF);
    add_tick(0, 32'hFFFF_FF00 + 32'd600, 16'd0);      // past one stagger
    add_tick(0, 32'hFFFF_FF00 + 32'd1100, 16'd0);     // past two staggers
    add_tick(0, 32'hFFFF_FF00 + 32'd1600, 16'd0);     // past three staggers
    add_tick(0, 32'hFFFF_FF00 + 32'd3000, 16'd0);     // last ramp-up tick
    add_tick(0, 32'hFFFF_FF00 + 32'd3500, 16'd0);     // hold
    add_tick(0, 32'hFFFF_FF00 + 32'd4000, 16'd0);     // still hold
    add_tick(0, 32'hFFFF_FF00 + 32'd4001, 16'd0);     // ramp down, time has wrapped
    add_tick(0, 32'hFFFF_FF00 + 32'd4200, 16'd0);
    add_tick(1, 32'h0000_0000, 16'hFFFF);
    add_tick(1, 32'hFFFF_FFFF, 16'd0);                // far past ramp down: ends at once
    add_tick(2, 32'h0000_0000, 16'd0);
    add_tick(2, 32'h8000_0000, 16'd1201);
    add_tick(2, 32'h8000_0010, 16'd0);
    add_tick(3, 32'h5555_5555, 16'hAAAA);
    add_tick(3, 32'hAAAA_AAAA, 16'h5555);
    add_tick(3, 32'hAAAA_AAAA, 16'h5555);             // idle again, restarts
    add_tick(3, 32'hAAAA_AAB0, 16'd0);
    wait_idle();

    // hold start above ramp-down start: no hold phase
    apply_setting(16'd500, 8'd12, 16'd200, 16'd80, 16'd15, 16'd0);
    random_ticks(PHASE_TICKS);
    wait_idle();
    random_setting();
    random_ticks(PHASE_TICKS);
    wait_idle();
    // top of every range: no new cycle can start, running ones climb
    apply_setting(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_ticks(PHASE_TICKS);
    wait_idle();
    // low ceiling under levels left from the climb
    apply_setting(16'd300, 8'd3, 16'd120, 16'd200, 16'd10, 16'd1);
    random_ticks(PHASE_TICKS);
    wait_idle();
    // bottom of every range
    apply_setting(16'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_ticks(PHASE_TICKS);
    wait_idle();
    for (int p = 0; p < 3; p++) begin
      random_setting();
      random_ticks(PHASE_TICKS);
      wait_idle();
    end
    repeat (8) @(posedge clk);

    $display("ran %0d ticks over %0d register settings, %0d result beats checked",
             ticks_sent, settings_done, results_seen);
    $display("%0d mismatches, %0d results still due", mismatches, levels_due.size());
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
